/* hdl/bb64_pkg.sv */
`default_nettype none
package bb64_pkg;

	// Field and register widths, sizes and depths
	localparam int unsigned LINE_LEN_W   = 10;
	localparam int unsigned COL_W        = 10;
	localparam int unsigned CHAR_W       = 7;
	localparam int unsigned BYTE_W       = 8;
	localparam int unsigned CFG_IDX_W    = 1;
	localparam int unsigned CFG_DATA_W   = 10;
	localparam int unsigned MAX_LINE_DEF = 1023;
	localparam int unsigned SLOTS        = 3;
	localparam int unsigned FIFO_DEPTH   = 2;

	// Register reset values
	localparam logic [LINE_LEN_W-1:0] LINE_LEN_RST = 10'd72;
	localparam logic                  WRAP_RST     = 1'b1;

	// Fixed characters
	localparam logic [CHAR_W-1:0] CH_PAD = 7'h3D;
	localparam logic [CHAR_W-1:0] CH_CR  = 7'h0D;
	localparam logic [CHAR_W-1:0] CH_LF  = 7'h0A;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 7'h2B;
	localparam logic [CHAR_W-1:0] CH_SLASH = 7'h2F;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LINE_LENGTH = 1'b0,
		REG_WRAP_MODE   = 1'b1
	} reg_idx_t;

	typedef enum logic {
		CMD_DATA = 1'b0,
		CMD_END  = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CR,
		ST_LF,
		ST_CHAR,
		ST_FCR,
		ST_FLF
	} back_state_t;

	// One input item, already turned into characters and line breaks
	typedef struct packed {
		logic [1:0]                    n;      // characters in this item
		logic [SLOTS-1:0][CHAR_W-1:0]  chars;
		logic [SLOTS-1:0]              wrap;   // CR LF before this character
		logic                          fcrlf;  // closing CR LF
	} entry_t;

	// Map a 6-bit code to the standard alphabet
	function automatic logic [CHAR_W-1:0] b64_char(input logic [5:0] code);
		logic [CHAR_W-1:0] c;
		c = {1'b0, code};
		if (code < 6'd26)
			return c + 7'h41;
		else if (code < 6'd52)
			return c + 7'h47;
		else if (code < 6'd62)
			return c - 7'h04;
		else if (code == 6'd62)
			return CH_PLUS;
		else
			return CH_SLASH;
	endfunction

endpackage
`default_nettype wire

/* hdl/bb64_ifs.sv */
`default_nettype none
interface bb64_req_if;
	logic                          valid;
	logic                          ready;
	logic                          cmd;
	logic [bb64_pkg::BYTE_W-1:0]   byte_value;

	modport source (output valid, cmd, byte_value, input ready);
	modport sink   (input valid, cmd, byte_value, output ready);
endinterface

interface bb64_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [bb64_pkg::CHAR_W-1:0]   out_char;
	logic                          run_last;

	modport source (output valid, out_char, run_last, input ready);
	modport sink   (input valid, out_char, run_last, output ready);
endinterface

interface bb64_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [bb64_pkg::CFG_IDX_W-1:0]  index;
	logic [bb64_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* hdl/bb64_front.sv */
`default_nettype none
module bb64_front #(
	parameter int unsigned MAX_LINE = bb64_pkg::MAX_LINE_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	bb64_req_if.sink         req,
	bb64_cfg_if.sink         cfg,
	input  wire logic        q_full,
	output logic             push,
	output bb64_pkg::entry_t push_ent
);

	localparam logic [16:0] MaxW = 17'(MAX_LINE);

	logic [bb64_pkg::LINE_LEN_W-1:0] line_len_q;
	logic                            wrap_q;
	logic [1:0]                      phase_q, phase_d;
	logic [5:0]                      carry_q, carry_d;
	logic [bb64_pkg::COL_W-1:0]      col_q, col_d, col_w;
	logic [bb64_pkg::LINE_LEN_W-1:0] limit;
	logic                            accept;
	bb64_pkg::entry_t                ent;

	assign cfg.ready = 1'b1;
	assign req.ready = !q_full;
	assign accept    = req.valid && req.ready;

	// Saturate line length to the largest supported line
	assign limit = ({7'd0, line_len_q} > MaxW) ? MaxW[bb64_pkg::LINE_LEN_W-1:0] : line_len_q;

	// Take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_len_q <= bb64_pkg::LINE_LEN_RST;
			wrap_q     <= bb64_pkg::WRAP_RST;
		end else if (cfg.valid) begin
			if (cfg.index == bb64_pkg::REG_LINE_LENGTH)
				line_len_q <= cfg.data;
			else if (cfg.index == bb64_pkg::REG_WRAP_MODE)
				wrap_q <= cfg.data[0];
		end
	end

	// Classify the item into characters
	always_comb begin
		ent     = '0;
		phase_d = phase_q;
		carry_d = carry_q;
		if (req.cmd == bb64_pkg::CMD_DATA) begin
			unique case (phase_q)
				2'd0: begin
					ent.chars[0] = bb64_pkg::b64_char(req.byte_value[7:2]);
					ent.n        = 2'd1;
					carry_d      = {req.byte_value[1:0], 4'b0000};
					phase_d      = 2'd1;
				end
				2'd1: begin
					ent.chars[0] = bb64_pkg::b64_char(carry_q | {2'b00, req.byte_value[7:4]});
					ent.n        = 2'd1;
					carry_d      = {req.byte_value[3:0], 2'b00};
					phase_d      = 2'd2;
				end
				default: begin
					ent.chars[0] = bb64_pkg::b64_char(carry_q | {4'b0000, req.byte_value[7:6]});
					ent.chars[1] = bb64_pkg::b64_char(req.byte_value[5:0]);
					ent.n        = 2'd2;
					carry_d      = '0;
					phase_d      = 2'd0;
				end
			endcase
		end else begin
			ent.chars[0] = bb64_pkg::b64_char(carry_q);
			ent.chars[1] = bb64_pkg::CH_PAD;
			ent.chars[2] = bb64_pkg::CH_PAD;
			if (phase_q == 2'd1)
				ent.n = 2'd3;
			else if (phase_q == 2'd2)
				ent.n = 2'd2;
			ent.fcrlf = wrap_q;
			carry_d   = '0;
			phase_d   = 2'd0;
		end

		// Walk the column over the characters of this item
		col_w = col_q;
		for (int k = 0; k < bb64_pkg::SLOTS; k++) begin
			if (k < int'(ent.n) && wrap_q) begin
				ent.wrap[k] = (col_w >= limit);
				col_w       = ent.wrap[k] ? 10'd1 : col_w + 10'd1;
			end
		end
		col_d = (req.cmd == bb64_pkg::CMD_END) ? '0 : col_w;
	end

	assign push     = accept && (ent.n != 2'd0 || ent.fcrlf);
	assign push_ent = ent;

	// Advance encoder state on accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			carry_q <= '0;
			col_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			carry_q <= carry_d;
			col_q   <= col_d;
		end
	end

endmodule
`default_nettype wire

/* hdl/bb64_fifo.sv */
`default_nettype none
module bb64_fifo (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire bb64_pkg::entry_t  push_ent,
	input  wire logic              pop,
	output bb64_pkg::entry_t       head,
	output logic                   not_empty,
	output logic                   full
);

	localparam int unsigned Depth = bb64_pkg::FIFO_DEPTH;
	localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW  = $clog2(Depth + 1);

	bb64_pkg::entry_t  mem_q [Depth];
	logic [PtrW-1:0]   wr_q, rd_q;
	logic [CntW-1:0]   cnt_q;

	assign head      = mem_q[rd_q];
	assign not_empty = (cnt_q != '0);
	assign full      = (cnt_q == CntW'(Depth));

	// Store the item
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_ent;
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("queue read while empty");

endmodule
`default_nettype wire

/* hdl/bb64_back.sv */
`default_nettype none
module bb64_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire bb64_pkg::entry_t  head,
	input  wire logic              q_valid,
	output logic                   pop,
	bb64_rsp_if.source             rsp
);

	bb64_pkg::back_state_t       st_q, st_d;
	bb64_pkg::entry_t            ent_q, ent_d;
	logic [1:0]                  idx_q, idx_d;
	logic                        slot_free, emit, sym_last, load;
	logic [bb64_pkg::CHAR_W-1:0] sym;
	logic                        out_valid_q, out_last_q;
	logic [bb64_pkg::CHAR_W-1:0] out_char_q;

	assign slot_free = !out_valid_q || rsp.ready;
	assign emit      = (st_q != bb64_pkg::ST_IDLE) && slot_free;

	// Next state and symbol
	always_comb begin
		st_d     = st_q;
		idx_d    = idx_q;
		ent_d    = ent_q;
		sym      = ent_q.chars[idx_q];
		sym_last = 1'b0;
		unique case (st_q)
			bb64_pkg::ST_IDLE: ;
			bb64_pkg::ST_CR: begin
				sym  = bb64_pkg::CH_CR;
				st_d = bb64_pkg::ST_LF;
			end
			bb64_pkg::ST_LF: begin
				sym  = bb64_pkg::CH_LF;
				st_d = bb64_pkg::ST_CHAR;
			end
			bb64_pkg::ST_CHAR: begin
				if (idx_q == ent_q.n - 2'd1) begin
					if (ent_q.fcrlf) begin
						st_d = bb64_pkg::ST_FCR;
					end else begin
						sym_last = 1'b1;
						st_d     = bb64_pkg::ST_IDLE;
					end
				end else begin
					idx_d = idx_q + 2'd1;
					st_d  = ent_q.wrap[idx_q + 2'd1] ? bb64_pkg::ST_CR : bb64_pkg::ST_CHAR;
				end
			end
			bb64_pkg::ST_FCR: begin
				sym  = bb64_pkg::CH_CR;
				st_d = bb64_pkg::ST_FLF;
			end
			bb64_pkg::ST_FLF: begin
				sym      = bb64_pkg::CH_LF;
				sym_last = 1'b1;
				st_d     = bb64_pkg::ST_IDLE;
			end
			default: st_d = bb64_pkg::ST_IDLE;
		endcase
		if (!emit) begin
			st_d  = st_q;
			idx_d = idx_q;
		end

		// Pick up the next item when idle or as the current one finishes
		load = q_valid && ((st_q == bb64_pkg::ST_IDLE) || (emit && sym_last));
		if (load) begin
			ent_d = head;
			idx_d = '0;
			if (head.n != 2'd0)
				st_d = head.wrap[0] ? bb64_pkg::ST_CR : bb64_pkg::ST_CHAR;
			else
				st_d = bb64_pkg::ST_FCR;
		end
	end

	assign pop = load;

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= bb64_pkg::ST_IDLE;
			idx_q <= '0;
		end else begin
			st_q  <= st_d;
			idx_q <= idx_d;
		end
	end

	always_ff @(posedge clk) begin
		ent_q <= ent_d;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit)
			out_valid_q <= 1'b1;
		else if (rsp.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_char_q <= sym;
			out_last_q <= sym_last;
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.out_char = out_char_q;
	assign rsp.run_last = out_last_q;

	a_cr_then_lf: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == bb64_pkg::ST_CR && emit) |=> (st_q == bb64_pkg::ST_LF))
		else $error("CR not followed by LF");

	a_final_lf_last: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == bb64_pkg::ST_FLF && emit) |=>
		(rsp.valid && rsp.run_last && rsp.out_char == bb64_pkg::CH_LF))
		else $error("closing LF not marked last");

	a_entry_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (head.n != 2'd0 || head.fcrlf))
		else $error("queued item has no results");

endmodule
`default_nettype wire

/* hdl/base64_stream_encoder_wrapped_unit.sv */
// Path: an item's results pass through the queue, the back-end item register and the
// output register. Throughput: one result per cycle at the output register while
// the receiver is ready; an item has 1 to 11 results, and the front accepts one item
// per cycle while the two-entry queue has room.
// Reset: arst_n clears phase, carry, column, queue and output valid; line_length
// returns to 72 and wrap_mode to 1.
`default_nettype none
module base64_stream_encoder_wrapped_unit #(
	parameter int unsigned MAX_LINE = bb64_pkg::MAX_LINE_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	bb64_req_if.sink    req,
	bb64_rsp_if.source  rsp,
	bb64_cfg_if.sink    cfg
);

	logic             push, pop, q_valid, q_full;
	bb64_pkg::entry_t push_ent, head;

	// Accept and classify items
	bb64_front #(
		.MAX_LINE (MAX_LINE)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cfg      (cfg),
		.q_full   (q_full),
		.push     (push),
		.push_ent (push_ent)
	);

	// Decouple front and back
	bb64_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_ent  (push_ent),
		.pop       (pop),
		.head      (head),
		.not_empty (q_valid),
		.full      (q_full)
	);

	// Emit characters one per cycle while the receiver is ready
	bb64_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.q_valid (q_valid),
		.pop     (pop),
		.rsp     (rsp)
	);

endmodule
`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

	localparam int PERIOD_HI   = 2;
	localparam int PERIOD_LO   = 2;
	localparam int RESET_LEN   = 12;
	localparam int SETTLE      = 6;
	localparam int LONG_STALL  = 300;
	localparam int QUIET_LIMIT = 5000;
	localparam int RAND_PHASES = 8;
	localparam int PHASE_ITEMS = 43;

	// One character leaving the encoder
	typedef struct packed {
		logic [bb64_pkg::CHAR_W-1:0] ch;
		logic                        last;
	} enc_char_t;

	// Tracks the encoder state and the characters still owed by the block
	class char_stream_board;
		logic [bb64_pkg::LINE_LEN_W-1:0] line_len;
		logic                            wrap_on;
		logic [1:0]                      group_pos;
		logic [5:0]                      leftover;
		logic [bb64_pkg::COL_W-1:0]      col;
		enc_char_t                       owed[$];
		enc_char_t                       step_chars[$];
		string                           alphabet;
		int                              errors;
		int                              n_items;
		int                              n_chars;
		int                              n_ends;
		int                              n_writes;

		function new();
			alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
			line_len = bb64_pkg::LINE_LEN_RST;
			wrap_on = bb64_pkg::WRAP_RST;
			group_pos = 2'd0;
			leftover = 6'd0;
			col = '0;
			errors = 0;
			n_items = 0;
			n_chars = 0;
			n_ends = 0;
			n_writes = 0;
		endfunction

		function int pending();
			return owed.size();
		endfunction

		function void write_reg(bb64_pkg::reg_idx_t idx,
		                        logic [bb64_pkg::CFG_DATA_W-1:0] value);
			n_writes++;
			if (idx == bb64_pkg::REG_LINE_LENGTH)
				line_len = value[bb64_pkg::LINE_LEN_W-1:0];
			else
				wrap_on = value[0];
		endfunction

		function void put_raw(logic [bb64_pkg::CHAR_W-1:0] ch);
			enc_char_t e;
			e.ch = ch;
			e.last = 1'b0;
			step_chars.push_back(e);
		endfunction

		// Break the line first when the column has hit the limit
		function void put_char(logic [bb64_pkg::CHAR_W-1:0] ch);
			if (wrap_on) begin
				if (col >= line_len) begin
					put_raw(bb64_pkg::CH_CR);
					put_raw(bb64_pkg::CH_LF);
					col = '0;
				end
				col = col + 1'b1;
			end
			put_raw(ch);
		endfunction

		function void put_code(logic [5:0] code);
			byte c;
			c = alphabet[code];
			put_char(c[bb64_pkg::CHAR_W-1:0]);
		endfunction

		// Work out every character one accepted item causes
		function void take_input(bb64_pkg::cmd_t c, logic [bb64_pkg::BYTE_W-1:0] b);
			step_chars.delete();
			n_items++;
			if (c == bb64_pkg::CMD_DATA) begin
				case (group_pos)
					2'd0: begin
						put_code(b[7:2]);
						leftover = {b[1:0], 4'd0};
						group_pos = 2'd1;
					end
					2'd1: begin
						put_code(leftover | {2'd0, b[7:4]});
						leftover = {b[3:0], 2'd0};
						group_pos = 2'd2;
					end
					default: begin
						put_code(leftover | {4'd0, b[7:6]});
						put_code(b[5:0]);
						leftover = 6'd0;
						group_pos = 2'd0;
					end
				endcase
			end else begin
				n_ends++;
				if (group_pos == 2'd1) begin
					put_code(leftover);
					put_char(bb64_pkg::CH_PAD);
					put_char(bb64_pkg::CH_PAD);
				end else if (group_pos == 2'd2) begin
					put_code(leftover);
					put_char(bb64_pkg::CH_PAD);
				end
				if (wrap_on) begin
					put_raw(bb64_pkg::CH_CR);
					put_raw(bb64_pkg::CH_LF);
				end
				group_pos = 2'd0;
				leftover = 6'd0;
				col = '0;
			end
			if (step_chars.size() > 0)
				step_chars[step_chars.size()-1].last = 1'b1;
			foreach (step_chars[i])
				owed.push_back(step_chars[i]);
		endfunction

		function void check_char(logic [bb64_pkg::CHAR_W-1:0] ch, logic last);
			enc_char_t e;
			n_chars++;
			if (owed.size() == 0) begin
				$error("unexpected out_char: got %h run_last %b", ch, last);
				errors++;
				return;
			end
			e = owed.pop_front();
			if (e.ch !== ch) begin
				$error("out_char: expected %h actual %h", e.ch, ch);
				errors++;
			end
			if (e.last !== last) begin
				$error("run_last: expected %b actual %b", e.last, last);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	bb64_req_if req_ch();
	bb64_rsp_if rsp_ch();
	bb64_cfg_if cfg_ch();

	base64_stream_encoder_wrapped_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	char_stream_board board = new();

	// Pacing shared by the sender and the receiver
	bit send_gaps;
	bit recv_stalls;
	int idle_pct;
	int stall_asks;
	int stall_taken;
	int stall_left;
	int quiet_cycles;

	always begin
		clk = 1'b1;
		#PERIOD_HI;
		clk = 1'b0;
		#PERIOD_LO;
	end

	// Receiver: random stalls, plus one long hold-off on request
	always @(posedge clk) begin
		if (stall_asks != stall_taken) begin
			stall_taken = stall_asks;
			stall_left = LONG_STALL;
		end
		if (stall_left > 0) begin
			stall_left--;
			rsp_ch.ready <= 1'b0;
		end else if (recv_stalls) begin
			rsp_ch.ready <= ($urandom_range(99) >= idle_pct);
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	// Check each accepted character
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			board.check_char(rsp_ch.out_char, rsp_ch.run_last);
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
		    (cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout after %0d quiet cycles", quiet_cycles);
				$display("tb_top NOT OK");
				$finish;
			end
		end
	end

	task automatic set_pacing(input bit s, input bit r, input int pct);
		send_gaps = s;
		recv_stalls = r;
		idle_pct = pct;
	endtask

	// Offer one item, idle first at random, hold until accepted
	task automatic send_item(input bb64_pkg::cmd_t c,
	                         input logic [bb64_pkg::BYTE_W-1:0] b);
		if (send_gaps && $urandom_range(99) < idle_pct) begin
			req_ch.valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < idle_pct);
		end
		req_ch.valid <= 1'b1;
		req_ch.cmd <= c;
		req_ch.byte_value <= b;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		board.take_input(c, b);
	endtask

	task automatic send_byte(input logic [bb64_pkg::BYTE_W-1:0] b);
		send_item(bb64_pkg::CMD_DATA, b);
	endtask

	task automatic send_end();
		send_item(bb64_pkg::CMD_END, 8'($urandom_range(255)));
	endtask

	// Stop sending and wait out every owed character plus the pipeline
	task automatic drain();
		req_ch.valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Write both registers back to back, valid held high in between
	task automatic write_config(input logic [bb64_pkg::LINE_LEN_W-1:0] len,
	                            input logic wrap);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= bb64_pkg::REG_LINE_LENGTH;
		cfg_ch.data <= len;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		board.write_reg(bb64_pkg::REG_LINE_LENGTH, len);
		cfg_ch.index <= bb64_pkg::REG_WRAP_MODE;
		cfg_ch.data <= {{(bb64_pkg::CFG_DATA_W-1){1'b0}}, wrap};
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		board.write_reg(bb64_pkg::REG_WRAP_MODE, {{(bb64_pkg::CFG_DATA_W-1){1'b0}}, wrap});
		cfg_ch.valid <= 1'b0;
	endtask

	// Mostly data with random content, extremes and stream ends mixed in
	task automatic send_random();
		int pick;
		pick = $urandom_range(99);
		if (pick < 8)
			send_end();
		else if (pick < 16)
			send_byte(8'h00);
		else if (pick < 24)
			send_byte(8'hFF);
		else
			send_byte(8'($urandom_range(255)));
	endtask

	initial begin
		logic [bb64_pkg::LINE_LEN_W-1:0] len;
		logic                            wrap;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.cmd <= bb64_pkg::CMD_DATA;
		req_ch.byte_value <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= bb64_pkg::REG_LINE_LENGTH;
		cfg_ch.data <= '0;
		stall_asks = 0;
		stall_taken = 0;
		stall_left = 0;
		quiet_cycles = 0;
		set_pacing(1'b0, 1'b0, 0);
		repeat (RESET_LEN) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset settings: full groups, alphabet ends, each end phase
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'hFB);
		send_byte(8'hEF);
		send_byte(8'hBE);
		send_end();
		send_byte(8'h4D);
		send_end();
		send_byte(8'h4D);
		send_byte(8'h61);
		send_end();
		drain();

		// Zero line length: break before every character
		write_config(10'd0, 1'b1);
		send_byte(8'h80);
		send_end();
		drain();

		// Plain mode mid-group, then switch to wrapped mid-line
		write_config(10'd3, 1'b0);
		send_byte(8'h01);
		send_byte(8'h02);
		drain();
		write_config(10'd3, 1'b1);
		send_byte(8'h03);
		send_byte(8'h04);
		send_byte(8'h05);
		drain();

		// Lower the limit to the current column
		write_config(10'd1, 1'b1);
		send_byte(8'h06);
		send_end();
		drain();

		// End in plain mode at a group boundary gives nothing
		write_config(10'd1023, 1'b0);
		send_end();
		drain();

		// Random phases over several settings and pacing modes
		for (int p = 0; p < RAND_PHASES; p++) begin
			case (p)
				0: begin len = 10'd72;   wrap = 1'b1; end
				1: begin len = 10'd1;    wrap = 1'b1; end
				2: begin len = 10'd1023; wrap = 1'b0; end
				3: begin len = 10'd0;    wrap = 1'b1; end
				4: begin len = 10'd1023; wrap = 1'b1; end
				5: begin len = 10'($urandom_range(9, 2)); wrap = 1'b1; end
				6: begin len = 10'($urandom_range(1023)); wrap = 1'($urandom_range(1)); end
				default: begin len = 10'd4; wrap = 1'b0; end
			endcase
			write_config(len, wrap);
			case (p % 4)
				0: set_pacing(1'b0, 1'b0, 0);
				1: set_pacing(1'b1, 1'b0, 81);
				2: set_pacing(1'b0, 1'b1, 81);
				default: set_pacing(1'b1, 1'b1, 18);
			endcase
			// Hold the output off while items keep coming, to fill the queue
			if (p == 0)
				stall_asks++;
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_random();
			drain();
		end

		set_pacing(1'b0, 1'b0, 0);
		drain();
		repeat (20) @(posedge clk);
		$display("covered %0d items (%0d stream ends), %0d characters checked",
			board.n_items, board.n_ends, board.n_chars);
		$display("register writes: %0d, line lengths 0 to 1023, both modes", board.n_writes);
		if (board.errors == 0 && board.pending() == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule
`default_nettype wire

/* filelist.f */
hdl/bb64_pkg.sv
hdl/bb64_ifs.sv
hdl/bb64_front.sv
hdl/bb64_fifo.sv
hdl/bb64_back.sv
hdl/base64_stream_encoder_wrapped_unit.sv
tb/tb_top.sv
